// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is disabled while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/biq_pkg.sv =====
// ----------------------------------------------------------------------------
// biq_pkg
// Types, constants, microcode table and rounding helpers of the biquad filter.
// ----------------------------------------------------------------------------
package biq_pkg;

   // Field and datapath widths.
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 18;
   localparam int DELAY_W  = 24;
   localparam int PROD_W   = COEF_W + DELAY_W;
   localparam int ACC_W    = 45;
   localparam int X_SHIFT  = 23;
   localparam int T_SHIFT  = 15;
   localparam int Y_SHIFT  = 23;
   localparam int T_SHR_W  = ACC_W - T_SHIFT;
   localparam int Y_SHR_W  = ACC_W - Y_SHIFT;

   // Register file.
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;
   localparam logic [2:0] REG_A0    = 3'd0;
   localparam logic [2:0] REG_A1    = 3'd1;
   localparam logic [2:0] REG_A2    = 3'd2;
   localparam logic [2:0] REG_B1    = 3'd3;
   localparam logic [2:0] REG_B2    = 3'd4;
   localparam logic [2:0] REG_MUTED = 3'd5;

   // Multiplier coefficient select.
   localparam logic [2:0] CSEL_A0 = 3'd0;
   localparam logic [2:0] CSEL_A1 = 3'd1;
   localparam logic [2:0] CSEL_A2 = 3'd2;
   localparam logic [2:0] CSEL_B1 = 3'd3;
   localparam logic [2:0] CSEL_B2 = 3'd4;

   // Multiplier operand select.
   localparam logic [1:0] OSEL_D1 = 2'd0;
   localparam logic [1:0] OSEL_D2 = 2'd1;
   localparam logic [1:0] OSEL_T  = 2'd2;

   // Accumulator operations.
   localparam logic [2:0] ACC_HOLD       = 3'd0;
   localparam logic [2:0] ACC_LOAD_X_SUB = 3'd1;
   localparam logic [2:0] ACC_SUB        = 3'd2;
   localparam logic [2:0] ACC_LOAD       = 3'd3;
   localparam logic [2:0] ACC_ADD        = 3'd4;

   // Sequencer jump conditions.
   localparam logic [1:0] JMP_NEXT     = 2'd0;
   localparam logic [1:0] JMP_WAIT_IN  = 2'd1;
   localparam logic [1:0] JMP_WAIT_OUT = 2'd2;

   localparam int STEP_W = 3;

   // Rounding and saturation bounds.
   localparam logic signed [ACC_W-1:0]   T_HALF    = ACC_W'(64'sd16384);
   localparam logic signed [ACC_W-1:0]   Y_HALF    = ACC_W'(64'sd4194304);
   localparam logic signed [T_SHR_W-1:0] T_MAX     = T_SHR_W'(64'sd8388607);
   localparam logic signed [T_SHR_W-1:0] T_MIN     = T_SHR_W'(-64'sd8388608);
   localparam logic signed [Y_SHR_W-1:0] Y_MAX     = Y_SHR_W'(64'sd32767);
   localparam logic signed [Y_SHR_W-1:0] Y_MIN     = Y_SHR_W'(-64'sd32768);
   localparam logic signed [DELAY_W-1:0] DELAY_MAX = 24'sh7FFFFF;
   localparam logic signed [DELAY_W-1:0] DELAY_MIN = 24'sh800000;
   localparam logic signed [SAMPLE_W-1:0] OUT_MAX  = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] OUT_MIN  = 16'sh8000;

   // One control word of the microprogram.
   typedef struct packed {
      logic [2:0] coef_sel;
      logic [1:0] opnd_sel;
      logic [2:0] acc_op;
      logic       latch_t;
      logic [1:0] jmp;
   } ucode_type;

   // Command from the sequencer to the datapath.
   typedef struct packed {
      ucode_type word;
      logic      load_x;
      logic      commit;
   } dp_cmd_type;

   // Configuration register contents.
   typedef struct packed {
      logic signed [COEF_W-1:0] a0;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic                     muted;
   } cfg_type;

   // Microprogram. The product register always holds the product chosen one
   // step earlier, so each step consumes the previous product.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '{coef_sel: CSEL_A0, opnd_sel: OSEL_D1, acc_op: ACC_HOLD,
            latch_t: 1'b0, jmp: JMP_NEXT};
      case (step)
         3'd0: begin
            // Wait for a sample; b1*d1 is formed while waiting.
            w.coef_sel = CSEL_B1; w.opnd_sel = OSEL_D1; w.jmp = JMP_WAIT_IN;
         end
         3'd1: begin
            w.coef_sel = CSEL_B2; w.opnd_sel = OSEL_D2; w.acc_op = ACC_LOAD_X_SUB;
         end
         3'd2: begin
            w.coef_sel = CSEL_A1; w.opnd_sel = OSEL_D1; w.acc_op = ACC_SUB;
         end
         3'd3: begin
            w.coef_sel = CSEL_A2; w.opnd_sel = OSEL_D2; w.acc_op = ACC_LOAD;
            w.latch_t  = 1'b1;
         end
         3'd4: begin
            w.coef_sel = CSEL_A0; w.opnd_sel = OSEL_T; w.acc_op = ACC_ADD;
         end
         3'd5: begin
            w.acc_op = ACC_ADD;
         end
         3'd6: begin
            w.jmp = JMP_WAIT_OUT;
         end
         default: begin
            w.jmp = JMP_WAIT_OUT;
         end
      endcase
      return w;
   endfunction

   // Round half up to Q8 and saturate to the delay word.
   function automatic logic signed [DELAY_W-1:0] round_delay(
      input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0]   sum;
      logic signed [T_SHR_W-1:0] shr;
      sum = acc + T_HALF;
      shr = sum[ACC_W-1:T_SHIFT];
      if (shr > T_MAX) begin
         return DELAY_MAX;
      end else if (shr < T_MIN) begin
         return DELAY_MIN;
      end
      return shr[DELAY_W-1:0];
   endfunction

   // Round half up to an integer and saturate to the output sample.
   function automatic logic signed [SAMPLE_W-1:0] round_sample(
      input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0]   sum;
      logic signed [Y_SHR_W-1:0] shr;
      sum = acc + Y_HALF;
      shr = sum[ACC_W-1:Y_SHIFT];
      if (shr > Y_MAX) begin
         return OUT_MAX;
      end else if (shr < Y_MIN) begin
         return OUT_MIN;
      end
      return shr[SAMPLE_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/biq_csr.sv =====
// ----------------------------------------------------------------------------
// biq_csr
// APB-style register file holding the filter coefficients and the mute bit.
// ----------------------------------------------------------------------------
module biq_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [biq_pkg::CSR_AW-1:0]    paddr,
   input  logic [biq_pkg::CSR_DW-1:0]    pwdata,
   output logic [biq_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready,
   output biq_pkg::cfg_type              cfg
);

   biq_pkg::cfg_type cfg_ff;
   biq_pkg::cfg_type cfg_in;
   logic [2:0]       reg_idx;
   logic             wr_en;

   assign reg_idx = paddr[biq_pkg::CSR_AW-1:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // Write decode; addresses beyond the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            biq_pkg::REG_A0:    cfg_in.a0    = pwdata[biq_pkg::COEF_W-1:0];
            biq_pkg::REG_A1:    cfg_in.a1    = pwdata[biq_pkg::COEF_W-1:0];
            biq_pkg::REG_A2:    cfg_in.a2    = pwdata[biq_pkg::COEF_W-1:0];
            biq_pkg::REG_B1:    cfg_in.b1    = pwdata[biq_pkg::COEF_W-1:0];
            biq_pkg::REG_B2:    cfg_in.b2    = pwdata[biq_pkg::COEF_W-1:0];
            biq_pkg::REG_MUTED: cfg_in.muted = pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux; coefficients read back sign-extended.
   always_comb begin
      case (reg_idx)
         biq_pkg::REG_A0: prdata = biq_pkg::CSR_DW'(cfg_ff.a0);
         biq_pkg::REG_A1: prdata = biq_pkg::CSR_DW'(cfg_ff.a1);
         biq_pkg::REG_A2: prdata = biq_pkg::CSR_DW'(cfg_ff.a2);
         biq_pkg::REG_B1: prdata = biq_pkg::CSR_DW'(cfg_ff.b1);
         biq_pkg::REG_B2: prdata = biq_pkg::CSR_DW'(cfg_ff.b2);
         biq_pkg::REG_MUTED: prdata = {{(biq_pkg::CSR_DW-1){1'b0}}, cfg_ff.muted};
         default: prdata = '0;
      endcase
   end

endmodule

// ===== hw/rtl/biq_sequencer.sv =====
// ----------------------------------------------------------------------------
// biq_sequencer
// Step counter and microcode lookup; owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module biq_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output biq_pkg::dp_cmd_type  cmd
);

   logic [biq_pkg::STEP_W-1:0] step_ff;
   logic [biq_pkg::STEP_W-1:0] step_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   biq_pkg::ucode_type         word;
   logic                       accept;
   logic                       slot_free;
   logic                       commit;

   // Control word for the current step.
   assign word = biq_pkg::ucode_rom(step_ff);

   assign req_ready = (word.jmp == biq_pkg::JMP_WAIT_IN);
   assign accept    = req_valid & req_ready;
   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign commit    = (word.jmp == biq_pkg::JMP_WAIT_OUT) & slot_free;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.word   = word;
   assign cmd.load_x = accept;
   assign cmd.commit = commit;

   // Next step from the jump condition.
   always_comb begin
      case (word.jmp)
         biq_pkg::JMP_NEXT:     step_in = step_ff + 3'd1;
         biq_pkg::JMP_WAIT_IN:  step_in = accept ? step_ff + 3'd1 : step_ff;
         biq_pkg::JMP_WAIT_OUT: step_in = commit ? '0 : step_ff;
         default:               step_in = '0;
      endcase
   end

   // Output beat is held until the receiver takes it.
   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/biq_datapath.sv =====
// ----------------------------------------------------------------------------
// biq_datapath
// Shared multiplier, accumulator, delay words and output sample register.
// ----------------------------------------------------------------------------
module biq_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  biq_pkg::dp_cmd_type                 cmd,
   input  biq_pkg::cfg_type                    cfg,
   input  logic signed [biq_pkg::SAMPLE_W-1:0] sample_in,
   output logic signed [biq_pkg::SAMPLE_W-1:0] sample_out
);

   logic signed [biq_pkg::SAMPLE_W-1:0] x_ff;
   logic signed [biq_pkg::DELAY_W-1:0]  d1_ff;
   logic signed [biq_pkg::DELAY_W-1:0]  d2_ff;
   logic signed [biq_pkg::DELAY_W-1:0]  t_ff;
   logic signed [biq_pkg::DELAY_W-1:0]  t_in;
   logic signed [biq_pkg::PROD_W-1:0]   prod_ff;
   logic signed [biq_pkg::PROD_W-1:0]   prod_in;
   logic signed [biq_pkg::ACC_W-1:0]    acc_ff;
   logic signed [biq_pkg::ACC_W-1:0]    acc_in;
   logic signed [biq_pkg::ACC_W-1:0]    prod_ext;
   logic signed [biq_pkg::ACC_W-1:0]    x_ext;
   logic signed [biq_pkg::COEF_W-1:0]   coef_mux;
   logic signed [biq_pkg::DELAY_W-1:0]  opnd_mux;
   logic signed [biq_pkg::SAMPLE_W-1:0] out_ff;
   logic signed [biq_pkg::SAMPLE_W-1:0] out_in;

   // Multiplier operand selection.
   always_comb begin
      case (cmd.word.coef_sel)
         biq_pkg::CSEL_A0: coef_mux = cfg.a0;
         biq_pkg::CSEL_A1: coef_mux = cfg.a1;
         biq_pkg::CSEL_A2: coef_mux = cfg.a2;
         biq_pkg::CSEL_B1: coef_mux = cfg.b1;
         biq_pkg::CSEL_B2: coef_mux = cfg.b2;
         default:          coef_mux = '0;
      endcase
      case (cmd.word.opnd_sel)
         biq_pkg::OSEL_D1: opnd_mux = d1_ff;
         biq_pkg::OSEL_D2: opnd_mux = d2_ff;
         biq_pkg::OSEL_T:  opnd_mux = t_ff;
         default:          opnd_mux = '0;
      endcase
   end

   // Product is registered before it reaches the accumulator.
   assign prod_in  = coef_mux * opnd_mux;
   assign prod_ext = {{(biq_pkg::ACC_W-biq_pkg::PROD_W){prod_ff[biq_pkg::PROD_W-1]}},
                      prod_ff};
   assign x_ext    = {{(biq_pkg::ACC_W-biq_pkg::SAMPLE_W-biq_pkg::X_SHIFT){x_ff[biq_pkg::SAMPLE_W-1]}},
                      x_ff, {biq_pkg::X_SHIFT{1'b0}}};

   // Accumulator.
   always_comb begin
      case (cmd.word.acc_op)
         biq_pkg::ACC_HOLD:       acc_in = acc_ff;
         biq_pkg::ACC_LOAD_X_SUB: acc_in = x_ext - prod_ext;
         biq_pkg::ACC_SUB:        acc_in = acc_ff - prod_ext;
         biq_pkg::ACC_LOAD:       acc_in = prod_ext;
         biq_pkg::ACC_ADD:        acc_in = acc_ff + prod_ext;
         default:                 acc_in = acc_ff;
      endcase
   end

   // Intermediate value and output; both are zero while muted.
   assign t_in   = cfg.muted ? '0 : biq_pkg::round_delay(acc_ff);
   assign out_in = cfg.muted ? '0 : biq_pkg::round_sample(acc_ff);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (cmd.load_x) begin
         x_ff <= sample_in;
      end
      if (cmd.word.latch_t) begin
         t_ff <= t_in;
      end
      if (cmd.commit) begin
         out_ff <= out_in;
      end
   end

   // Delay line shifts once per sample, when the result is committed.
   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= '0;
         d2_ff <= '0;
      end else if (cmd.commit) begin
         d1_ff <= t_ff;
         d2_ff <= d1_ff;
      end
   end

   assign sample_out = out_ff;

endmodule

// ===== hw/rtl/biquad_iir_filter_top.sv =====
// ----------------------------------------------------------------------------
// biquad_iir_filter_top
// Direct form II biquad filter driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
// - Input samples arrive as req_ beats (req_valid/req_ready, req_sample_in),
//   filtered samples leave as rsp_ beats (rsp_valid/rsp_ready, rsp_sample_out).
//   Every input beat gives exactly one output beat, in order.
// - Coefficients a0, a1, a2, b1, b2 (Q2.15) and the mute bit sit at byte
//   addresses 0, 4, 8, 12, 16 and 20 of the APB-style port; write them only
//   while no sample is in flight.
// - One sample walks a seven-step microprogram through a single shared
//   18x24 multiplier: five products plus the load and commit steps.
// - A sample's output beat is presented after its commit step; a new sample
//   is taken only after that commit, paced by the shared multiplier.
// - The output register holds the finished sample while the receiver stalls;
//   the sequencer waits on its commit step until the slot frees up.
// - Synchronous reset clears the coefficients, the mute bit, both delay words
//   and the output valid; req_ready is high right after reset.
// ----------------------------------------------------------------------------
module biquad_iir_filter_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [biq_pkg::SAMPLE_W-1:0] req_sample_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [biq_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [biq_pkg::CSR_AW-1:0]          paddr,
   input  logic [biq_pkg::CSR_DW-1:0]          pwdata,
   output logic [biq_pkg::CSR_DW-1:0]          prdata,
   output logic                                pready
);

   biq_pkg::cfg_type    cfg;
   biq_pkg::dp_cmd_type cmd;

   // Configuration registers.
   biq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Microprogram sequencer.
   biq_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Arithmetic datapath.
   biq_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg),
      .sample_in  (req_sample_in),
      .sample_out (rsp_sample_out)
   );

endmodule

// ===== hw/rtl/biq_checker.sv =====
// ----------------------------------------------------------------------------
// biq_checker
// Port-level checks of the biquad filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module biq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [biq_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input logic                                pready
);

   // A stalled output beat keeps its value.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sample_out)))

   // Only one sample is in flight: ready drops after an input beat.
   `ASSERT_CLK_RST(a_one_in_flight, clock, reset, (req_valid && req_ready) |=> !req_ready)

   // No output beat appears in the cycle right after an input beat.
   `ASSERT_CLK_RST(a_no_instant_rsp, clock, reset, (req_valid && req_ready) |=> !$rose(rsp_valid))

   // After reset the block is empty and ready for a sample.
   `ASSERT_CLK(a_reset_state, clock, reset |=> (req_ready && !rsp_valid && pready))

endmodule

bind biquad_iir_filter_top biq_checker u_biq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sample_out (rsp_sample_out),
   .pready         (pready)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the biquad IIR filter.
// ----------------------------------------------------------------------------
// A directed table first walks the edge cases: reset coefficients, unity and
// full-scale gains of both signs, the mute bit, register writes with junk in
// the high bits and writes to unused addresses. Random phases with designed,
// extreme and random coefficients follow. Every output beat is compared with
// a typed-in value or with a bit-accurate fixed-point model of the filter
// kept in this file. Both channels idle at random, and the receiver holds
// off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb;

   localparam int N_DIRECTED      = 38;
   localparam int N_PHASES        = 8;
   localparam int ITEMS_PER_PHASE = 185;
   localparam int MUTED_PHASE     = 4;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int SETTLE_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT  = 2000;

   // Addresses past the register list; writes there must change nothing.
   localparam logic [2:0] REG_SPARE_LO = 3'd6;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

   localparam logic [biq_pkg::COEF_W-1:0] COEF_ONE = 18'h08000;
   localparam logic [biq_pkg::COEF_W-1:0] COEF_MAX = 18'h1FFFF;
   localparam logic [biq_pkg::COEF_W-1:0] COEF_MIN = 18'h20000;

   localparam logic [2:0] COEF_REGS [5] = '{biq_pkg::REG_A0, biq_pkg::REG_A1,
                                            biq_pkg::REG_A2, biq_pkg::REG_B1,
                                            biq_pkg::REG_B2};
   localparam logic [biq_pkg::COEF_W-1:0] COEF_EDGES [4] =
      '{COEF_MAX, COEF_MIN, 18'h00000, COEF_ONE};

   // Designed sections, ordered a0, a1, a2, b1, b2: low-pass and high-pass at
   // an eighth of the sample rate, and a narrow resonant band-pass.
   localparam logic [biq_pkg::COEF_W-1:0] DESIGNED [3][5] = '{
      '{18'sd3199, 18'sd6399, 18'sd3199, -18'sd30893, 18'sd10923},
      '{18'sd18646, -18'sd37292, 18'sd18646, -18'sd30893, 18'sd10923},
      '{18'sd1638, 18'sd0, -18'sd1638, -18'sd62259, 18'sd31130}
   };

   localparam logic signed [biq_pkg::SAMPLE_W-1:0] SAMPLE_EDGES [5] =
      '{biq_pkg::OUT_MAX, biq_pkg::OUT_MIN, 16'sd0, 16'sd1, -16'sd1};

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;
   typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE} rx_pattern_type;
   typedef enum logic [1:0] {STYLE_DESIGNED, STYLE_EDGES, STYLE_RANDOM} coef_style_type;

   typedef struct packed {
      row_kind_type                         kind;
      logic [2:0]                           reg_idx;
      logic [31:0]                          value;
      logic signed [biq_pkg::SAMPLE_W-1:0]  sample;
      logic                                 known;
      logic signed [biq_pkg::SAMPLE_W-1:0]  want;
   } stim_row_type;

   // Directed table. Outputs are typed in where they follow at a glance from
   // the gains in force; the other rows are checked against the model.
   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, biq_pkg::OUT_MAX, 1'b1, 16'sd0},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, biq_pkg::OUT_MIN, 1'b1, 16'sd0},
      '{ROW_WRITE, biq_pkg::REG_A0, 32'h0000_8000, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, biq_pkg::OUT_MAX, 1'b1, biq_pkg::OUT_MAX},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, biq_pkg::OUT_MIN, 1'b1, biq_pkg::OUT_MIN},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, 16'sd1, 1'b1, 16'sd1},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, -16'sd1, 1'b1, -16'sd1},
      '{ROW_WRITE, biq_pkg::REG_A0, 32'hFFFD_FFFF, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, biq_pkg::OUT_MAX, 1'b1, biq_pkg::OUT_MAX},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, biq_pkg::OUT_MIN, 1'b1, biq_pkg::OUT_MIN},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, 16'sd1000, 1'b0, 16'sd0},
      '{ROW_WRITE, biq_pkg::REG_A0, 32'h0002_0000, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, biq_pkg::OUT_MAX, 1'b1, biq_pkg::OUT_MIN},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, biq_pkg::OUT_MIN, 1'b1, biq_pkg::OUT_MAX},
      '{ROW_WRITE, biq_pkg::REG_MUTED, 32'h0000_0001, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, 16'sd12345, 1'b1, 16'sd0},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, biq_pkg::OUT_MIN, 1'b1, 16'sd0},
      '{ROW_WRITE, REG_SPARE_LO, 32'hFFFF_FFFF, 16'sd0, 1'b0, 16'sd0},
      '{ROW_WRITE, REG_SPARE_HI, 32'hFFFF_FFFF, 16'sd0, 1'b0, 16'sd0},
      '{ROW_WRITE, biq_pkg::REG_MUTED, 32'hFFFF_FFFE, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, biq_pkg::OUT_MIN, 1'b1, biq_pkg::OUT_MAX},
      '{ROW_WRITE, biq_pkg::REG_A0, 32'h0000_8000, 16'sd0, 1'b0, 16'sd0},
      '{ROW_WRITE, biq_pkg::REG_A1, 32'h0001_FFFF, 16'sd0, 1'b0, 16'sd0},
      '{ROW_WRITE, biq_pkg::REG_A2, 32'h0002_0000, 16'sd0, 1'b0, 16'sd0},
      '{ROW_WRITE, biq_pkg::REG_B1, 32'h0001_FFFF, 16'sd0, 1'b0, 16'sd0},
      '{ROW_WRITE, biq_pkg::REG_B2, 32'h0002_0000, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, biq_pkg::OUT_MAX, 1'b0, 16'sd0},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, biq_pkg::OUT_MAX, 1'b0, 16'sd0},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, biq_pkg::OUT_MIN, 1'b0, 16'sd0},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, biq_pkg::OUT_MIN, 1'b0, 16'sd0},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, 16'sd21845, 1'b0, 16'sd0},
      '{ROW_WRITE, biq_pkg::REG_B1, 32'h0002_0000, 16'sd0, 1'b0, 16'sd0},
      '{ROW_WRITE, biq_pkg::REG_B2, 32'h0001_FFFF, 16'sd0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, biq_pkg::OUT_MAX, 1'b0, 16'sd0},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, biq_pkg::OUT_MIN, 1'b0, 16'sd0},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, biq_pkg::OUT_MAX, 1'b0, 16'sd0},
      '{ROW_SAMPLE, biq_pkg::REG_A0, 32'h0, 16'sd0, 1'b0, 16'sd0}
   };

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic signed [biq_pkg::SAMPLE_W-1:0]  req_sample_in = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic signed [biq_pkg::SAMPLE_W-1:0]  rsp_sample_out;
   logic                                 psel = 1'b0;
   logic                                 penable = 1'b0;
   logic                                 pwrite = 1'b0;
   logic [biq_pkg::CSR_AW-1:0]           paddr = '0;
   logic [biq_pkg::CSR_DW-1:0]           pwdata = '0;
   logic [biq_pkg::CSR_DW-1:0]           prdata;
   logic                                 pready;

   // Filter model: coefficients, mute bit and the two delay words.
   biq_pkg::cfg_type                     model_cfg = '0;
   logic signed [biq_pkg::DELAY_W-1:0]   model_d1 = '0;
   logic signed [biq_pkg::DELAY_W-1:0]   model_d2 = '0;

   logic signed [biq_pkg::SAMPLE_W-1:0]  pending_out [$];
   logic signed [biq_pkg::SAMPLE_W-1:0]  oldest_out;
   int                                   burst_left = 0;
   bit                                   hold_off_req = 1'b0;
   int                                   idle_cycles = 0;
   int                                   mismatches = 0;
   int                                   beats_checked = 0;
   int                                   samples_sent = 0;
   int                                   reg_writes = 0;

   biquad_iir_filter_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      if (v < lo) begin
         return lo;
      end else if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   // Register write as the block sees it: high bits are dropped, and the
   // unused addresses change nothing.
   function automatic void apply_register(input logic [2:0] idx, input logic [31:0] value);
      case (idx)
         biq_pkg::REG_A0:    model_cfg.a0 = value[biq_pkg::COEF_W-1:0];
         biq_pkg::REG_A1:    model_cfg.a1 = value[biq_pkg::COEF_W-1:0];
         biq_pkg::REG_A2:    model_cfg.a2 = value[biq_pkg::COEF_W-1:0];
         biq_pkg::REG_B1:    model_cfg.b1 = value[biq_pkg::COEF_W-1:0];
         biq_pkg::REG_B2:    model_cfg.b2 = value[biq_pkg::COEF_W-1:0];
         biq_pkg::REG_MUTED: model_cfg.muted = value[0];
         default: ;
      endcase
   endfunction

   // One sample through the direct form II section. Products are exact at
   // Q23; t rounds half up to Q8 and y to an integer, and both saturate.
   function automatic logic signed [biq_pkg::SAMPLE_W-1:0] filter_sample(
      input logic signed [biq_pkg::SAMPLE_W-1:0] x);
      longint acc;
      longint t_val;
      longint y_val;
      if (model_cfg.muted) begin
         t_val = 0;
         y_val = 0;
      end else begin
         acc = (longint'(x) <<< biq_pkg::X_SHIFT)
             - longint'($signed(model_cfg.b1)) * longint'(model_d1)
             - longint'($signed(model_cfg.b2)) * longint'(model_d2);
         t_val = clamp((acc + 64'sd16384) >>> biq_pkg::T_SHIFT,
                       -64'sd8388608, 64'sd8388607);
         acc = longint'($signed(model_cfg.a0)) * t_val
             + longint'($signed(model_cfg.a1)) * longint'(model_d1)
             + longint'($signed(model_cfg.a2)) * longint'(model_d2);
         y_val = clamp((acc + 64'sd4194304) >>> biq_pkg::Y_SHIFT,
                       -64'sd32768, 64'sd32767);
      end
      model_d2 = model_d1;
      model_d1 = t_val[biq_pkg::DELAY_W-1:0];
      return y_val[biq_pkg::SAMPLE_W-1:0];
   endfunction

   // Offer one input beat. Beats come in bursts; valid drops only for a real gap.
   task automatic send_sample(input logic signed [biq_pkg::SAMPLE_W-1:0] x,
                              input logic known,
                              input logic signed [biq_pkg::SAMPLE_W-1:0] want);
      int   gap;
      logic took;
      logic signed [biq_pkg::SAMPLE_W-1:0] predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_sample_in <= x;
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (!took);
      predicted = filter_sample(x);
      pending_out.push_back(known ? want : predicted);
      samples_sent++;
   endtask

   // Stop offering and let every sample leave the block. An idle stretch
   // then separates the traffic from the register writes that follow.
   task automatic quiesce();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup and access phase, then the bus goes idle.
   task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
      logic done;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         done = pready;
         @(posedge clock);
      end while (!done);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      apply_register(idx, value);
      reg_writes++;
      @(posedge clock);
   endtask

   // New settings for one random phase, with junk above the register width
   // on about half of the coefficient writes and on the mute write.
   task automatic configure_phase(input int phase);
      coef_style_type                style;
      int                            pick;
      logic [biq_pkg::COEF_W-1:0]    code;
      logic [31:0]                   junk;
      style = coef_style_type'(phase % 3);
      pick  = $urandom_range(0, 2);
      for (int k = 0; k < 5; k++) begin
         case (style)
            STYLE_DESIGNED: code = DESIGNED[pick][k];
            STYLE_EDGES: begin
               code = ($urandom_range(0, 4) == 4) ? biq_pkg::COEF_W'($urandom)
                                                  : COEF_EDGES[$urandom_range(0, 3)];
            end
            default: code = biq_pkg::COEF_W'($urandom);
         endcase
         junk = $urandom_range(0, 1) ? $urandom : 32'h0;
         write_register(COEF_REGS[k], {junk[31:biq_pkg::COEF_W], code});
      end
      junk = $urandom;
      write_register(biq_pkg::REG_MUTED, {junk[31:1], phase == MUTED_PHASE});
      if (phase % 2 == 1) begin
         write_register(REG_SPARE_LO, $urandom);
         write_register(REG_SPARE_HI, $urandom);
      end
   endtask

   // Mostly full-scale random samples, with the rails and small values mixed in.
   function automatic logic signed [biq_pkg::SAMPLE_W-1:0] draw_sample();
      int kind;
      int v;
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
         return biq_pkg::SAMPLE_W'($urandom);
      end else if (kind < 75) begin
         return SAMPLE_EDGES[$urandom_range(0, 4)];
      end
      v = int'($urandom_range(0, 512)) - 256;
      return v[biq_pkg::SAMPLE_W-1:0];
   endfunction

   // Receiver: stretches of free flow, coin-flip stalls and sparse readiness,
   // plus a long hold-off on request.
   initial begin
      rx_pattern_type pattern;
      int             run_left;
      pattern  = RX_FREE;
      run_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         if (run_left == 0) begin
            pattern  = rx_pattern_type'($urandom_range(0, 2));
            run_left = $urandom_range(10, 200);
         end
         run_left--;
         case (pattern)
            RX_FREE: rsp_ready <= 1'b1;
            RX_COIN: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Output check. Inputs move only at the rising edge, so a beat that is
   // valid and ready here is taken at the next edge.
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_out.size() == 0) begin
            $error("sample_out: got %0d with no sample outstanding", rsp_sample_out);
            mismatches++;
         end else begin
            oldest_out = pending_out.pop_front();
            beats_checked++;
            if (rsp_sample_out !== oldest_out) begin
               $error("sample_out: expected %0d, got %0d", oldest_out, rsp_sample_out);
               mismatches++;
            end
         end
      end
   end

   // Watchdog on cycles without any beat on either channel or the bus.
   always @(negedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no beat for %0d cycles, %0d samples outstanding.",
                  idle_cycles, pending_out.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Main sequence: reset, directed table, random phases, drain.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_DIRECTED; r++) begin
         if (DIRECTED[r].kind == ROW_WRITE) begin
            quiesce();
            write_register(DIRECTED[r].reg_idx, DIRECTED[r].value);
         end else begin
            send_sample(DIRECTED[r].sample, DIRECTED[r].known, DIRECTED[r].want);
         end
      end

      for (int p = 0; p < N_PHASES; p++) begin
         quiesce();
         configure_phase(p);
         // Fill the block while the receiver holds off.
         if (p == 1 || p == 5) begin
            hold_off_req = 1'b1;
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_sample(draw_sample(), 1'b0, '0);
         end
      end

      quiesce();
      $display("Filtered %0d samples through %0d register writes and %0d coefficient phases.",
               samples_sent, reg_writes, N_PHASES);
      $display("Checked %0d output beats, %0d mismatches.", beats_checked, mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
